// ----- src/crp_pkg.sv -----
// shared constants and types for the catmull-rom point interpolator
package crp_pkg;

    localparam int SAMPLES_DEF     = 34;
    localparam int COORD_W_DEF     = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // sample numerator: 2*p1*DEN_HALF + a*COEF_A*k + b*COEF_B*k^2 + c*COEF_C*k^3
    localparam int DEN_HALF = 1000000;
    localparam int DEN_FULL = 2000000;
    localparam int COEF_A   = 30000;
    localparam int COEF_B   = 900;
    localparam int COEF_C   = 27;

    // DEN_FULL = SCALE_ODD << SCALE_SHIFT
    localparam int SCALE_SHIFT = 7;
    localparam int SCALE_ODD   = 15625;

    // width margins above the coordinate width, sized for up to 64 samples
    localparam int NUM_GUARD   = 29;
    localparam int X_EXTRA     = 14;
    localparam int M_EXTRA     = 15;
    localparam int SHIFT_EXTRA = 28;

    typedef struct packed {
        logic       seg;
        logic       last;
        logic [1:0] count;
    } job_ctrl_t;

    typedef struct packed {
        logic p1_load;
        logic p2_load;
        logic it_load;
        logic it_step;
        logic pipe_adv;
    } axis_ctrl_t;

endpackage

// ----- src/crp_front.sv -----
// front end: point window, list tracking and job generation
module crp_front #(
    parameter int COORD_WIDTH = crp_pkg::COORD_W_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [COORD_WIDTH-1:0]         s_point_x,
    input  logic [COORD_WIDTH-1:0]         s_point_y,
    input  logic                           s_last_point,
    input  logic                           push_ready,
    output logic                           push_valid,
    output crp_pkg::job_ctrl_t             push_ctrl,
    output logic [3:0][COORD_WIDTH-1:0]    push_px,
    output logic [3:0][COORD_WIDTH-1:0]    push_py
);

    localparam logic [1:0] HELD_FULL = 2'd3;

    logic [1:0]                  held_reg, held_next;
    logic [2:0][COORD_WIDTH-1:0] win_x_reg, win_x_next;
    logic [2:0][COORD_WIDTH-1:0] win_y_reg, win_y_next;
    logic                        accept;

    assign s_ready = push_ready;
    assign accept  = s_valid && push_ready;

    always_comb begin
        held_next  = held_reg;
        win_x_next = win_x_reg;
        win_y_next = win_y_reg;
        push_valid = 1'b0;
        push_ctrl  = '0;
        push_px    = '0;
        push_py    = '0;

        if (held_reg == HELD_FULL) begin
            push_ctrl.seg   = 1'b1;
            push_ctrl.last  = s_last_point;
            push_ctrl.count = 2'd0;
            push_px = {s_point_x, win_x_reg[2], win_x_reg[1], win_x_reg[0]};
            push_py = {s_point_y, win_y_reg[2], win_y_reg[1], win_y_reg[0]};
        end else begin
            // short list end: held points, then the current one
            push_ctrl.seg   = 1'b0;
            push_ctrl.last  = 1'b1;
            push_ctrl.count = held_reg + 2'd1;
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < held_reg) begin
                    push_px[i] = win_x_reg[i];
                    push_py[i] = win_y_reg[i];
                end else begin
                    push_px[i] = s_point_x;
                    push_py[i] = s_point_y;
                end
            end
            push_px[3] = s_point_x;
            push_py[3] = s_point_y;
        end

        if (accept) begin
            if (held_reg == HELD_FULL) begin
                push_valid = 1'b1;
                if (s_last_point) begin
                    held_next = 2'd0;
                end else begin
                    win_x_next = {s_point_x, win_x_reg[2], win_x_reg[1]};
                    win_y_next = {s_point_y, win_y_reg[2], win_y_reg[1]};
                end
            end else if (s_last_point) begin
                push_valid = 1'b1;
                held_next  = 2'd0;
            end else begin
                win_x_next[held_reg] = s_point_x;
                win_y_next[held_reg] = s_point_y;
                held_next            = held_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= 2'd0;
        end else begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_x_reg <= win_x_next;
        win_y_reg <= win_y_next;
    end

endmodule

// ----- src/crp_queue.sv -----
// short job queue between front end and sample engine
module crp_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = crp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [AW:0]   CNT_FULL = (AW + 1)'(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]       count_reg;
    logic              do_push, do_pop;

    assign push_ready = count_reg != CNT_FULL;
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/crp_axis.sv -----
// one coordinate axis: coefficient prep, forward-difference stepper, scale and clip
module crp_axis #(
    parameter int COORD_WIDTH = crp_pkg::COORD_W_DEF
) (
    input  logic                        aclk,
    input  crp_pkg::axis_ctrl_t         ctrl,
    input  logic [3:0][COORD_WIDTH-1:0] p,
    output logic [COORD_WIDTH-1:0]      result
);

    localparam int W     = COORD_WIDTH;
    localparam int A_W   = W + 1;
    localparam int B_W   = W + 4;
    localparam int C_W   = W + 3;
    localparam int NW    = W + crp_pkg::NUM_GUARD;
    localparam int XW    = W + crp_pkg::X_EXTRA;
    localparam int MW    = W + crp_pkg::M_EXTRA;
    localparam int DIV_SHIFT = W + crp_pkg::SHIFT_EXTRA;
    localparam int XL    = (XW + 1) / 2;
    localparam int XH    = XW - XL;
    localparam int ML    = (MW + 1) / 2;
    localparam int MH    = MW - ML;
    localparam int S0_W  = XL + MW;
    localparam int S1_W  = XH + MW;
    localparam int PW    = XW + MW;

    localparam logic signed [NW-1:0] K_A   = NW'(crp_pkg::COEF_A);
    localparam logic signed [NW-1:0] K_B   = NW'(crp_pkg::COEF_B);
    localparam logic signed [NW-1:0] K_C   = NW'(crp_pkg::COEF_C);
    localparam logic signed [NW-1:0] K_DEN = NW'(crp_pkg::DEN_FULL);
    localparam logic signed [NW-1:0] LIMIT = NW'(64'(crp_pkg::DEN_FULL) << W);
    // reciprocal of the odd part of the divisor, rounded up
    localparam logic [MW-1:0] MREC =
        MW'(((64'd1 << DIV_SHIFT) / 64'(crp_pkg::SCALE_ODD)) + 64'd1);
    localparam logic [ML-1:0] M_LO = MREC[ML-1:0];
    localparam logic [MH-1:0] M_HI = MREC[MW-1:ML];

    logic signed [B_W-1:0] e0, e1, e2, e3;

    logic signed [A_W-1:0] a_reg;
    logic signed [B_W-1:0] b_reg;
    logic signed [C_W-1:0] c_reg;
    logic [W-1:0]          p1_reg;

    logic signed [NW-1:0]  ca_reg, cb_reg, cc_reg, n0_reg;
    logic signed [NW-1:0]  num_reg, d1_reg, d2_reg, d3_reg;

    logic                  neg1_reg, ovf1_reg;
    logic [XW-1:0]         x1_reg;
    logic                  neg2_reg, ovf2_reg;
    logic [XL+ML-1:0]      pp_ll_reg;
    logic [XL+MH-1:0]      pp_lh_reg;
    logic [XH+ML-1:0]      pp_hl_reg;
    logic [XH+MH-1:0]      pp_hh_reg;
    logic                  neg3_reg, ovf3_reg;
    logic [S0_W-1:0]       s0_reg;
    logic [S1_W-1:0]       s1_reg;

    logic [PW-1:0]         prod;
    logic [W-1:0]          quot;

    assign e0 = $signed(B_W'(p[0]));
    assign e1 = $signed(B_W'(p[1]));
    assign e2 = $signed(B_W'(p[2]));
    assign e3 = $signed(B_W'(p[3]));

    // coefficient prep, two stages
    always_ff @(posedge aclk) begin
        if (ctrl.p1_load) begin
            a_reg  <= A_W'(e2 - e0);
            b_reg  <= (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
            c_reg  <= C_W'(((e1 <<< 1) + e1) - ((e2 <<< 1) + e2) + e3 - e0);
            p1_reg <= p[1];
        end
        if (ctrl.p2_load) begin
            ca_reg <= NW'(a_reg) * K_A;
            cb_reg <= NW'(b_reg) * K_B;
            cc_reg <= NW'(c_reg) * K_C;
            n0_reg <= $signed(NW'(p1_reg)) * K_DEN;
        end
    end

    // cubic in k stepped by forward differences
    always_ff @(posedge aclk) begin
        if (ctrl.it_load) begin
            num_reg <= n0_reg;
            d1_reg  <= ca_reg + cb_reg + cc_reg;
            d2_reg  <= (cb_reg <<< 1) + (cc_reg <<< 2) + (cc_reg <<< 1);
            d3_reg  <= (cc_reg <<< 2) + (cc_reg <<< 1);
        end else if (ctrl.it_step) begin
            num_reg <= num_reg + d1_reg;
            d1_reg  <= d1_reg + d2_reg;
            d2_reg  <= d2_reg + d3_reg;
        end
    end

    // divide by the scale: shift out the power of two, then reciprocal multiply
    always_ff @(posedge aclk) begin
        if (ctrl.pipe_adv) begin
            neg1_reg  <= num_reg[NW-1];
            ovf1_reg  <= !num_reg[NW-1] && (num_reg >= LIMIT);
            x1_reg    <= num_reg[crp_pkg::SCALE_SHIFT +: XW];

            neg2_reg  <= neg1_reg;
            ovf2_reg  <= ovf1_reg;
            pp_ll_reg <= x1_reg[XL-1:0] * M_LO;
            pp_lh_reg <= x1_reg[XL-1:0] * M_HI;
            pp_hl_reg <= x1_reg[XW-1:XL] * M_LO;
            pp_hh_reg <= x1_reg[XW-1:XL] * M_HI;

            neg3_reg  <= neg2_reg;
            ovf3_reg  <= ovf2_reg;
            s0_reg    <= S0_W'(pp_ll_reg) + (S0_W'(pp_lh_reg) << ML);
            s1_reg    <= S1_W'(pp_hl_reg) + (S1_W'(pp_hh_reg) << ML);
        end
    end

    assign prod = PW'(s0_reg) + (PW'(s1_reg) << XL);
    assign quot = prod[DIV_SHIFT +: W];

    always_comb begin
        if (neg3_reg) begin
            result = '0;
        end else if (ovf3_reg) begin
            result = '1;
        end else begin
            result = quot;
        end
    end

endmodule

// ----- src/crp_back.sv -----
// sample engine: job sequencing, per-axis datapaths and result register
module crp_back #(
    parameter int COORD_WIDTH         = crp_pkg::COORD_W_DEF,
    parameter int SAMPLES_PER_SEGMENT = crp_pkg::SAMPLES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    output logic                        q_pop,
    input  crp_pkg::job_ctrl_t          q_ctrl,
    input  logic [3:0][COORD_WIDTH-1:0] q_px,
    input  logic [3:0][COORD_WIDTH-1:0] q_py,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [COORD_WIDTH-1:0]      m_sample_x,
    output logic [COORD_WIDTH-1:0]      m_sample_y,
    output logic                        m_last_sample
);

    localparam int W  = COORD_WIDTH;
    localparam int KW = $clog2(SAMPLES_PER_SEGMENT);
    localparam int CW = (KW > 2) ? KW : 2;
    localparam logic [CW-1:0] K_LAST = CW'(SAMPLES_PER_SEGMENT - 1);

    crp_pkg::axis_ctrl_t actl;

    logic                 p1_valid_reg, p2_valid_reg, it_active_reg;
    crp_pkg::job_ctrl_t   p1_ctrl_reg, p2_ctrl_reg, it_ctrl_reg;
    logic [2:0][W-1:0]    p1_bx_reg, p1_by_reg, p2_bx_reg, p2_by_reg;
    logic [2:0][W-1:0]    it_bx_reg, it_by_reg;
    logic [CW-1:0]        it_cnt_reg;

    logic                 v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic                 byp1_reg, byp2_reg, byp3_reg;
    logic                 last1_reg, last2_reg, last3_reg;
    logic [W-1:0]         bx1_reg, bx2_reg, bx3_reg, by1_reg, by2_reg, by3_reg;
    logic [W-1:0]         m_sample_x_reg, m_sample_y_reg;
    logic                 m_last_sample_reg;

    logic                 adv, emit, it_end, done, it_load, p2_take, p1_take;
    logic [W-1:0]         res_x, res_y;

    assign adv     = !m_valid_reg || m_ready;
    assign it_end  = it_ctrl_reg.seg ? (it_cnt_reg == K_LAST)
                                     : (it_cnt_reg == CW'(it_ctrl_reg.count - 2'd1));
    assign emit    = it_active_reg && adv;
    assign done    = emit && it_end;
    assign it_load = p2_valid_reg && (!it_active_reg || done);
    assign p2_take = p1_valid_reg && (!p2_valid_reg || it_load);
    assign p1_take = q_valid && (!p1_valid_reg || p2_take);
    assign q_pop   = p1_take;

    always_comb begin
        actl.p1_load  = p1_take;
        actl.p2_load  = p2_take;
        actl.it_load  = it_load;
        actl.it_step  = emit;
        actl.pipe_adv = adv;
    end

    crp_axis #(.COORD_WIDTH(W)) u_axis_x (
        .aclk   (aclk),
        .ctrl   (actl),
        .p      (q_px),
        .result (res_x)
    );

    crp_axis #(.COORD_WIDTH(W)) u_axis_y (
        .aclk   (aclk),
        .ctrl   (actl),
        .p      (q_py),
        .result (res_y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            it_active_reg <= 1'b0;
            it_cnt_reg    <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (p1_take) begin
                p1_valid_reg <= 1'b1;
            end else if (p2_take) begin
                p1_valid_reg <= 1'b0;
            end
            if (p2_take) begin
                p2_valid_reg <= 1'b1;
            end else if (it_load) begin
                p2_valid_reg <= 1'b0;
            end
            if (it_load) begin
                it_active_reg <= 1'b1;
                it_cnt_reg    <= '0;
            end else if (emit) begin
                if (it_end) begin
                    it_active_reg <= 1'b0;
                    it_cnt_reg    <= '0;
                end else begin
                    it_cnt_reg <= it_cnt_reg + 1'b1;
                end
            end
            if (adv) begin
                v1_reg      <= emit;
                v2_reg      <= v1_reg;
                v3_reg      <= v2_reg;
                m_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_take) begin
            p1_ctrl_reg <= q_ctrl;
            p1_bx_reg   <= q_px[2:0];
            p1_by_reg   <= q_py[2:0];
        end
        if (p2_take) begin
            p2_ctrl_reg <= p1_ctrl_reg;
            p2_bx_reg   <= p1_bx_reg;
            p2_by_reg   <= p1_by_reg;
        end
        if (it_load) begin
            it_ctrl_reg <= p2_ctrl_reg;
            it_bx_reg   <= p2_bx_reg;
            it_by_reg   <= p2_by_reg;
        end
        if (adv) begin
            // pass-through points ride beside the axis pipelines
            byp1_reg  <= !it_ctrl_reg.seg;
            last1_reg <= it_ctrl_reg.last && it_end;
            bx1_reg   <= it_bx_reg[it_cnt_reg[1:0]];
            by1_reg   <= it_by_reg[it_cnt_reg[1:0]];

            byp2_reg  <= byp1_reg;
            last2_reg <= last1_reg;
            bx2_reg   <= bx1_reg;
            by2_reg   <= by1_reg;

            byp3_reg  <= byp2_reg;
            last3_reg <= last2_reg;
            bx3_reg   <= bx2_reg;
            by3_reg   <= by2_reg;

            m_sample_x_reg    <= byp3_reg ? bx3_reg : res_x;
            m_sample_y_reg    <= byp3_reg ? by3_reg : res_y;
            m_last_sample_reg <= last3_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_sample_x    = m_sample_x_reg;
    assign m_sample_y    = m_sample_y_reg;
    assign m_last_sample = m_last_sample_reg;

endmodule

// ----- src/catmull_rom_point_interpolator_top.sv -----
// catmull-rom point interpolator, top level
// output: a segment point yields SAMPLES_PER_SEGMENT samples from the sample stepper,
// a short-list end yields one sample per point sent, a stored point yields none
// the input side runs ahead through a QUEUE_DEPTH job queue
// reset: synchronous active-low aresetn empties the queue and pipelines and starts a new list
module catmull_rom_point_interpolator_top #(
    parameter int SAMPLES_PER_SEGMENT = crp_pkg::SAMPLES_DEF,
    parameter int COORD_WIDTH         = crp_pkg::COORD_W_DEF,
    parameter int QUEUE_DEPTH         = crp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [COORD_WIDTH-1:0] s_point_x,
    input  logic [COORD_WIDTH-1:0] s_point_y,
    input  logic                   s_last_point,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COORD_WIDTH-1:0] m_sample_x,
    output logic [COORD_WIDTH-1:0] m_sample_y,
    output logic                   m_last_sample
);

    localparam int JOB_W = $bits(crp_pkg::job_ctrl_t) + 8 * COORD_WIDTH;

    logic                           push_valid, push_ready;
    crp_pkg::job_ctrl_t             push_ctrl, q_ctrl;
    logic [3:0][COORD_WIDTH-1:0]    push_px, push_py, q_px, q_py;
    logic [JOB_W-1:0]               push_data, pop_data;
    logic                           q_valid, q_pop;

    crp_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_point_x    (s_point_x),
        .s_point_y    (s_point_y),
        .s_last_point (s_last_point),
        .push_ready   (push_ready),
        .push_valid   (push_valid),
        .push_ctrl    (push_ctrl),
        .push_px      (push_px),
        .push_py      (push_py)
    );

    assign push_data = {push_ctrl, push_px, push_py};

    crp_queue #(.DATA_W(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_data   (pop_data)
    );

    assign {q_ctrl, q_px, q_py} = pop_data;

    crp_back #(
        .COORD_WIDTH         (COORD_WIDTH),
        .SAMPLES_PER_SEGMENT (SAMPLES_PER_SEGMENT)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_ctrl        (q_ctrl),
        .q_px          (q_px),
        .q_py          (q_py),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample_x    (m_sample_x),
        .m_sample_y    (m_sample_y),
        .m_last_sample (m_last_sample)
    );

endmodule

// ----- tb/catmull_rom_point_interpolator_top_test.sv -----
// self-checking testbench for the catmull-rom point interpolator top level
`timescale 1ns / 1ps

module catmull_rom_point_interpolator_top_test;

    localparam int SEGMENT_SAMPLES = 34;
    localparam int COORD_BITS      = 16;
    localparam int COORD_MAX       = (1 << COORD_BITS) - 1;
    localparam int HALF_SCALE      = 1000000;
    localparam int FULL_SCALE      = 2000000;
    localparam int LIN_WEIGHT      = 30000;
    localparam int SQ_WEIGHT       = 900;
    localparam int CUBE_WEIGHT     = 27;
    localparam int MAX_GAP         = 11;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 30;
    localparam int CYCLE_LIMIT     = 600000;

    typedef enum int {
        STYLE_RANDOM,
        STYLE_EXTREME,
        STYLE_SMOOTH
    } coord_style_t;

    typedef struct {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  last;
    } sample_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [COORD_BITS-1:0] s_point_x;
    logic [COORD_BITS-1:0] s_point_y;
    logic                  s_last_point;
    logic                  m_valid;
    logic                  m_ready;
    logic [COORD_BITS-1:0] m_sample_x;
    logic [COORD_BITS-1:0] m_sample_y;
    logic                  m_last_sample;

    // predictor state: held control points, oldest first
    logic [COORD_BITS-1:0] held_x [3];
    logic [COORD_BITS-1:0] held_y [3];
    int unsigned           held_count;

    sample_t     expected_samples [$];
    int          mismatch_count;
    longint      cycle_count;
    bit          source_steady;
    bit          sink_steady;
    int          hold_request;

    catmull_rom_point_interpolator_top #(
        .SAMPLES_PER_SEGMENT(SEGMENT_SAMPLES),
        .COORD_WIDTH        (COORD_BITS)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_point_x    (s_point_x),
        .s_point_y    (s_point_y),
        .s_last_point (s_last_point),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_x   (m_sample_x),
        .m_sample_y   (m_sample_y),
        .m_last_sample(m_last_sample)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // one spline coordinate, exact integer form, truncated toward zero then clipped
    function automatic logic [COORD_BITS-1:0] spline_coord(longint p0, longint p1,
                                                           longint p2, longint p3,
                                                           longint k);
        longint a;
        longint b;
        longint c;
        longint num;
        longint v;
        a   = p2 - p0;
        b   = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c   = -p0 + 3 * p1 - 3 * p2 + p3;
        num = 2 * p1 * HALF_SCALE + a * LIN_WEIGHT * k + b * SQ_WEIGHT * k * k
            + c * CUBE_WEIGHT * k * k * k;
        v   = num / FULL_SCALE;
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return COORD_MAX[COORD_BITS-1:0];
        return v[COORD_BITS-1:0];
    endfunction

    function automatic void push_sample(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                                        logic last);
        sample_t s;
        s.x    = x;
        s.y    = y;
        s.last = last;
        expected_samples.insert(expected_samples.size(), s);
    endfunction

    function automatic void predict_point(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                                          logic last);
        if (held_count < 3) begin
            if (last) begin
                for (int i = 0; i < held_count; i++)
                    push_sample(held_x[i], held_y[i], 1'b0);
                push_sample(x, y, 1'b1);
                held_count = 0;
            end else begin
                held_x[held_count] = x;
                held_y[held_count] = y;
                held_count++;
            end
            return;
        end
        for (int k = 0; k < SEGMENT_SAMPLES; k++)
            push_sample(spline_coord(held_x[0], held_x[1], held_x[2], x, k),
                        spline_coord(held_y[0], held_y[1], held_y[2], y, k),
                        last && (k == SEGMENT_SAMPLES - 1));
        if (last) begin
            held_count = 0;
        end else begin
            held_x[0] = held_x[1];
            held_x[1] = held_x[2];
            held_x[2] = x;
            held_y[0] = held_y[1];
            held_y[1] = held_y[2];
            held_y[2] = y;
        end
    endfunction

    task automatic send_point(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                              logic last);
        int gap;
        gap = source_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_point_x    <= x;
        s_point_y    <= y;
        s_last_point <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_point(x, y, last);
    endtask

    // sender goes quiet until every predicted sample has come out
    task automatic wait_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [COORD_BITS-1:0] pick_coord(coord_style_t style,
                                                         logic [COORD_BITS-1:0] prev);
        int sel;
        case (style)
            STYLE_EXTREME: begin
                sel = $urandom_range(0, 2);
                if (sel == 0)
                    return '0;
                if (sel == 1)
                    return COORD_MAX[COORD_BITS-1:0];
                return COORD_BITS'($urandom);
            end
            STYLE_SMOOTH: begin
                return prev + COORD_BITS'($urandom_range(0, 4000)) - COORD_BITS'(2000);
            end
            default: begin
                return COORD_BITS'($urandom);
            end
        endcase
    endfunction

    task automatic send_list(int len, coord_style_t style);
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        x = COORD_BITS'($urandom);
        y = COORD_BITS'($urandom);
        for (int i = 0; i < len; i++) begin
            x = pick_coord(style, x);
            y = pick_coord(style, y);
            send_point(x, y, i == len - 1);
        end
    endtask

    // lists of one, two and three points come back unchanged
    task automatic test_short_lists();
        send_point(16'h0000, 16'hffff, 1'b1);
        send_point(16'hffff, 16'h0000, 1'b0);
        send_point(16'h1234, 16'hfedc, 1'b1);
        send_point(16'h5555, 16'haaaa, 1'b0);
        send_point(16'haaaa, 16'h5555, 1'b0);
        send_point(16'h0001, 16'h8000, 1'b1);
        wait_drain();
    endtask

    // zigzag control points between both ends of the coordinate range
    task automatic test_clipped_segments();
        send_point(16'h0000, 16'hffff, 1'b0);
        send_point(16'hffff, 16'h0000, 1'b0);
        send_point(16'h0000, 16'hffff, 1'b0);
        send_point(16'hffff, 16'h0000, 1'b1);
        send_point(16'hffff, 16'hffff, 1'b0);
        send_point(16'h0000, 16'h0000, 1'b0);
        send_point(16'hffff, 16'hffff, 1'b0);
        send_point(16'h0000, 16'h0000, 1'b1);
        wait_drain();
    endtask

    // several segments in one list, last flag only on the final sample
    task automatic test_long_list();
        send_point(16'd100,   16'd60000, 1'b0);
        send_point(16'd5000,  16'd50000, 1'b0);
        send_point(16'd20000, 16'd30000, 1'b0);
        send_point(16'd40000, 16'd31000, 1'b0);
        send_point(16'd41000, 16'd2000,  1'b0);
        send_point(16'd65000, 16'd10,    1'b1);
        wait_drain();
    endtask

    task automatic test_flat_list();
        repeat (3) send_point(16'h8001, 16'h7ffe, 1'b0);
        send_point(16'h8001, 16'h7ffe, 1'b1);
        wait_drain();
    endtask

    // receiver stalls long while the sender keeps pushing, so the input side backs up
    task automatic test_backpressure();
        source_steady = 1'b1;
        hold_request  = HOLD_CYCLES;
        send_list(12, STYLE_RANDOM);
        wait_drain();
        source_steady = 1'b0;
    endtask

    task automatic test_random_lists();
        int           sent;
        int           len;
        coord_style_t style;
        for (int phase = 0; phase < 4; phase++) begin
            source_steady = (phase == 1) || (phase == 3);
            sink_steady   = (phase == 1) || (phase == 2);
            sent = 0;
            while (sent < 30) begin
                if ($urandom_range(0, 9) < 2)
                    len = $urandom_range(1, 3);
                else
                    len = $urandom_range(4, 9);
                style = coord_style_t'($urandom_range(0, 2));
                send_list(len, style);
                sent += len;
            end
            wait_drain();
        end
        source_steady = 1'b0;
        sink_steady   = 1'b0;
    endtask

    // result receiver with per-item random ready gaps, no gaps when steady, one long hold on request
    initial begin
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_request > 0) begin
                gap          = hold_request;
                hold_request = 0;
            end else if (sink_steady) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        sample_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected item x=%0d y=%0d last=%0d", $time,
                         m_sample_x, m_sample_y, m_last_sample);
                mismatch_count++;
            end else begin
                want = expected_samples.pop_front();
                if (m_sample_x !== want.x) begin
                    $display("%0t: sample_x expected %0d, got %0d", $time, want.x, m_sample_x);
                    mismatch_count++;
                end
                if (m_sample_y !== want.y) begin
                    $display("%0t: sample_y expected %0d, got %0d", $time, want.y, m_sample_y);
                    mismatch_count++;
                end
                if (m_last_sample !== want.last) begin
                    $display("%0t: last_sample expected %0d, got %0d", $time, want.last,
                             m_last_sample);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_point_x      = '0;
        s_point_y      = '0;
        s_last_point   = 1'b0;
        held_count     = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        source_steady  = 1'b0;
        sink_steady    = 1'b0;
        hold_request   = 0;
        for (int i = 0; i < 3; i++) begin
            held_x[i] = '0;
            held_y[i] = '0;
        end
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_short_lists();
        test_clipped_segments();
        test_long_list();
        test_flat_list();
        test_backpressure();
        test_random_lists();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_samples.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/crp_pkg.sv
src/crp_front.sv
src/crp_queue.sv
src/crp_axis.sv
src/crp_back.sv
src/catmull_rom_point_interpolator_top.sv
tb/catmull_rom_point_interpolator_top_test.sv
